/* hw/rtl/hmm_sfs_pkg.sv */
// shared types and constants of the hmm scaled forward step block
package hmm_sfs_pkg;

    // fixed field widths
    localparam int PROB_W         = 17;
    localparam int PROB_FRAC_BITS = 16;
    localparam int ROW_W          = 4;
    localparam int COL_W          = 3;
    localparam int SYM_W          = 4;
    localparam int STIDX_W        = 3;
    localparam int SCALE_W        = 32;
    localparam int ACT_W          = 4;
    localparam int OP_W           = 2;

    // defaults for the top level parameters
    localparam int DEF_MAX_STATES  = 8;
    localparam int DEF_MAX_SYMBOLS = 16;

    // active state count after reset
    localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

    // item kinds
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_TRANS = 2'd0,
        OP_LOAD_EMIS  = 2'd1,
        OP_LOAD_INIT  = 2'd2,
        OP_OBSERVE    = 2'd3
    } op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic mac_issue;
        logic row_first;
        logic pe_read;
        logic pmul;
        logic zmul;
        logic w_store;
        logic scale_clear;
        logic div_scale;
        logic div_alpha;
        logic scale_latch;
        logic alpha_latch;
        logic out_load;
        logic out_last;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic sum_zero;
    } dp_status_t;

endpackage

/* hw/rtl/hmm_scaled_forward_step.sv */
// Scaled HMM forward step. Load beats (opcode 0..2) write one table entry each.
// An observation beat with n active states runs n columns of the transition
// matrix product on one shared multiplier (on a sequence start, one product of
// initial and emission probability per state instead), then, unless the sum is
// zero, a 33-step bit-serial divider for the scale and a 17-step division per
// state for the normalized weight plus its result beat. One result beat per
// active state, tlast on the last; the next beat is taken while the last
// result still waits.
module hmm_scaled_forward_step #(
    parameter int MAX_STATES  = hmm_sfs_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = hmm_sfs_pkg::DEF_MAX_SYMBOLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: active_states
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // row_index, col_index, prob_value, symbol
    input  logic [2:0]  s_tuser,  // opcode, sequence_start
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // state_index, alpha_value, scale_factor
    output logic        m_tuser,  // zero_sum
    output logic        m_tlast
);
    import hmm_sfs_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int NW = $clog2(MAX_STATES + 1);

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [SW-1:0]      idx_i, idx_j;
    logic [NW-1:0]      n_act;
    logic               in_accept;
    op_t                in_op;
    logic [STIDX_W-1:0] out_state;
    logic [PROB_W-1:0]  out_alpha;
    logic [SCALE_W-1:0] out_scale;

    assign in_accept = s_tvalid && s_tready;
    assign in_op     = op_t'(s_tuser[1:0]);

    hmm_sfs_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .in_op(in_op),
        .in_start(s_tuser[2]), .m_tready(m_tready), .m_tvalid(m_tvalid),
        .cmd(cmd), .status(status), .idx_i(idx_i), .idx_j(idx_j), .n_act(n_act)
    );

    hmm_sfs_dp #(.MAX_STATES(MAX_STATES), .MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_accept(in_accept), .in_op(in_op),
        .in_row(s_tdata[3:0]), .in_col(s_tdata[6:4]), .in_prob(s_tdata[23:7]),
        .in_sym(s_tdata[27:24]), .cmd(cmd), .status(status), .idx_i(idx_i),
        .idx_j(idx_j), .n_act(n_act), .out_state(out_state),
        .out_alpha(out_alpha), .out_scale(out_scale), .out_zero(m_tuser),
        .out_last(m_tlast)
    );

    // result payload packing
    assign m_tdata = {4'b0, out_scale, out_alpha, out_state};

endmodule

/* hw/rtl/hmm_sfs_ram.sv */
// generic single port write, single port read ram with registered read
module hmm_sfs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/hmm_sfs_div.sv */
// restoring divider, one quotient bit per cycle
module hmm_sfs_div #(
    parameter int DEN_W = 25,
    parameter int Q_W   = 33,
    localparam int CNT_W = $clog2(Q_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DEN_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [CNT_W-1:0] steps,
    output logic             busy,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    logic             busy_reg, done_reg, first_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   rem_reg, rem_next, rem_sh;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic             ge;

    // one compare and subtract step
    always_comb begin
        rem_sh    = first_reg ? rem_reg : {rem_reg[DEN_W-1:0], 1'b0};
        ge        = (rem_sh >= {1'b0, den});
        rem_next  = ge ? (rem_sh - {1'b0, den}) : rem_sh;
        quot_next = {quot_reg[Q_W-2:0], ge};
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                cnt_reg   <= steps;
            end else if (busy_reg) begin
                first_reg <= 1'b0;
                cnt_reg   <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, num};
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a preceding run");

endmodule

/* hw/rtl/hmm_sfs_dp.sv */
// datapath: tables, shared multiplier, accumulator, divider and result register
module hmm_sfs_dp #(
    parameter int MAX_STATES  = 8,
    parameter int MAX_SYMBOLS = 16,
    localparam int SW = $clog2(MAX_STATES),
    localparam int NW = $clog2(MAX_STATES + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // accepted input beat
    input  logic                             in_accept,
    input  hmm_sfs_pkg::op_t                 in_op,
    input  logic [hmm_sfs_pkg::ROW_W-1:0]    in_row,
    input  logic [hmm_sfs_pkg::COL_W-1:0]    in_col,
    input  logic [hmm_sfs_pkg::PROB_W-1:0]   in_prob,
    input  logic [hmm_sfs_pkg::SYM_W-1:0]    in_sym,
    // controller side
    input  hmm_sfs_pkg::dp_cmd_t             cmd,
    output hmm_sfs_pkg::dp_status_t          status,
    input  logic [SW-1:0]                    idx_i,
    input  logic [SW-1:0]                    idx_j,
    input  logic [NW-1:0]                    n_act,
    // result register
    output logic [hmm_sfs_pkg::STIDX_W-1:0]  out_state,
    output logic [hmm_sfs_pkg::PROB_W-1:0]   out_alpha,
    output logic [hmm_sfs_pkg::SCALE_W-1:0]  out_scale,
    output logic                             out_zero,
    output logic                             out_last
);
    import hmm_sfs_pkg::*;

    localparam int YW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int TD    = MAX_STATES * MAX_STATES;
    localparam int TA_W  = $clog2(TD);
    localparam int ED    = MAX_SYMBOLS * MAX_STATES;
    localparam int EA_W  = $clog2(ED);
    localparam int ACC_W = 2 * PROB_W + SW;
    localparam int Z_W   = ACC_W - PROB_FRAC_BITS;
    localparam int MUL_W = Z_W + PROB_W;
    localparam int W_W   = MUL_W - PROB_FRAC_BITS;
    localparam int SUM_W = W_W + SW;
    localparam int Q_W   = PROB_FRAC_BITS + 17;
    localparam int CNT_W = $clog2(Q_W + 1);

    // table write decode
    logic            t_we, e_we, p_we;
    logic [TA_W-1:0] t_waddr, t_raddr;
    logic [EA_W-1:0] e_waddr, e_raddr;
    logic [SW-1:0]   p_waddr;
    logic [PROB_W-1:0] t_q, e_q, p_q;

    always_comb begin
        t_we    = in_accept && (in_op == OP_LOAD_TRANS) &&
                  (32'(in_row) < MAX_STATES) && (32'(in_col) < MAX_STATES);
        e_we    = in_accept && (in_op == OP_LOAD_EMIS) &&
                  (32'(in_row) < MAX_SYMBOLS) && (32'(in_col) < MAX_STATES);
        p_we    = in_accept && (in_op == OP_LOAD_INIT) && (32'(in_row) < MAX_STATES);
        t_waddr = TA_W'(32'(in_row) * MAX_STATES + 32'(in_col));
        e_waddr = EA_W'(32'(in_row) * MAX_STATES + 32'(in_col));
        p_waddr = SW'(in_row);
    end

    // symbol folded into the table range
    logic [SYM_W-1:0] sym_mod;
    logic [YW-1:0]    sym_reg;

    always_comb begin
        sym_mod = in_sym;
        for (int k = 0; k < 8; k++) begin
            if (32'(sym_mod) >= MAX_SYMBOLS) begin
                sym_mod = sym_mod - SYM_W'(MAX_SYMBOLS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && (in_op == OP_OBSERVE)) begin
            sym_reg <= YW'(sym_mod);
        end
    end

    // table read addresses
    always_comb begin
        t_raddr = TA_W'(32'(idx_j) * MAX_STATES + 32'(idx_i));
        e_raddr = EA_W'(32'(sym_reg) * MAX_STATES + 32'(idx_i));
    end

    hmm_sfs_ram #(.WIDTH(PROB_W), .DEPTH(TD)) u_trans (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(in_prob),
        .re(cmd.mac_issue), .raddr(t_raddr), .rdata(t_q)
    );

    hmm_sfs_ram #(.WIDTH(PROB_W), .DEPTH(ED)) u_emis (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(in_prob),
        .re(cmd.mac_issue || cmd.pe_read), .raddr(e_raddr), .rdata(e_q)
    );

    hmm_sfs_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES)) u_init (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(in_prob),
        .re(cmd.pe_read), .raddr(idx_i), .rdata(p_q)
    );

    // forward vector, read one entry a cycle during the mac
    logic [PROB_W-1:0] fv_reg [MAX_STATES];
    logic [PROB_W-1:0] fv_rd_reg;
    logic              v1_reg, v2_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mac_issue) begin
            fv_rd_reg <= fv_reg[idx_j];
        end
    end

    // mac pipeline tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    // shared multiplier
    logic [Z_W-1:0]    mul_a;
    logic [PROB_W-1:0] mul_b;
    logic [MUL_W-1:0]  prod_reg;
    logic [ACC_W-1:0]  acc_reg;

    always_comb begin
        priority if (v1_reg) begin
            mul_a = Z_W'(fv_rd_reg);
            mul_b = t_q;
        end else if (cmd.zmul) begin
            mul_a = acc_reg[ACC_W-1:PROB_FRAC_BITS];
            mul_b = e_q;
        end else begin
            mul_a = Z_W'(p_q);
            mul_b = e_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg || cmd.zmul || cmd.pmul) begin
            prod_reg <= MUL_W'(mul_a) * MUL_W'(mul_b);
        end
    end

    // accumulator over one column of the transition matrix
    always_ff @(posedge aclk) begin
        if (cmd.mac_issue && cmd.row_first) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // unnormalized weights and their sum
    logic [W_W-1:0]   w_reg [MAX_STATES];
    logic [W_W-1:0]   w_new;
    logic [SUM_W-1:0] sum_reg;

    assign w_new = prod_reg[MUL_W-1:PROB_FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (cmd.w_store) begin
            w_reg[idx_i] <= w_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && (in_op == OP_OBSERVE)) begin
            sum_reg <= '0;
        end else if (cmd.w_store) begin
            sum_reg <= sum_reg + SUM_W'(w_new);
        end
    end

    // divider shared by the scale and the normalization
    logic             div_start, div_busy, div_done;
    logic [SUM_W-1:0] div_num;
    logic [CNT_W-1:0] div_steps;
    logic [Q_W-1:0]   div_q;

    always_comb begin
        div_start = cmd.div_scale || cmd.div_alpha;
        div_num   = cmd.div_scale ? SUM_W'(1) : SUM_W'(w_reg[idx_i]);
        div_steps = cmd.div_scale ? CNT_W'(Q_W) : CNT_W'(PROB_FRAC_BITS + 1);
    end

    hmm_sfs_div #(.DEN_W(SUM_W), .Q_W(Q_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(sum_reg), .steps(div_steps), .busy(div_busy), .done(div_done),
        .quot(div_q)
    );

    // scale with saturation, normalized weight
    logic [63:0]          q_ext;
    logic [SCALE_W-1:0]   scale_sat, scale_reg;
    logic [PROB_W-1:0]    alpha_reg;

    always_comb begin
        q_ext     = 64'(div_q);
        scale_sat = (|q_ext[63:SCALE_W]) ? '1 : q_ext[SCALE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.scale_clear) begin
            scale_reg <= '0;
        end else if (cmd.scale_latch) begin
            scale_reg <= scale_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alpha_latch) begin
            alpha_reg <= status.sum_zero ? '0 : div_q[PROB_W-1:0];
        end
    end

    // forward vector update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_STATES; k++) begin
                fv_reg[k] <= '0;
            end
        end else if (cmd.scale_clear) begin
            for (int k = 0; k < MAX_STATES; k++) begin
                if (k >= 32'(n_act)) begin
                    fv_reg[k] <= '0;
                end
            end
        end else if (cmd.out_load) begin
            fv_reg[idx_i] <= alpha_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_state <= STIDX_W'(idx_i);
            out_alpha <= alpha_reg;
            out_scale <= scale_reg;
            out_zero  <= status.sum_zero;
            out_last  <= cmd.out_last;
        end
    end

    always_comb begin
        status.div_done = div_done;
        status.sum_zero = (sum_reg == '0);
    end

    a_zmul_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.zmul |-> !v1_reg && !v2_reg)
        else $error("weight multiply while the mac pipeline is busy");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started during a running division");

endmodule

/* hw/rtl/hmm_sfs_ctrl.sv */
// controller: sequences loads, mac rows, scale, normalization and result beats
module hmm_sfs_ctrl #(
    parameter int MAX_STATES = 8,
    localparam int SW = $clog2(MAX_STATES),
    localparam int NW = $clog2(MAX_STATES + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [hmm_sfs_pkg::ACT_W-1:0] cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  hmm_sfs_pkg::op_t             in_op,
    input  logic                         in_start,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output hmm_sfs_pkg::dp_cmd_t         cmd,
    input  hmm_sfs_pkg::dp_status_t      status,
    output logic [SW-1:0]                idx_i,
    output logic [SW-1:0]                idx_j,
    output logic [NW-1:0]                n_act
);
    import hmm_sfs_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0000000000001,
        ST_ISSUE      = 13'b0000000000010,
        ST_DRAIN1     = 13'b0000000000100,
        ST_DRAIN2     = 13'b0000000001000,
        ST_ZMUL       = 13'b0000000010000,
        ST_PREAD      = 13'b0000000100000,
        ST_PMUL       = 13'b0000001000000,
        ST_WSTORE     = 13'b0000010000000,
        ST_SCALE      = 13'b0000100000000,
        ST_SCALE_WAIT = 13'b0001000000000,
        ST_DIV        = 13'b0010000000000,
        ST_DIV_WAIT   = 13'b0100000000000,
        ST_OUT        = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [SW-1:0]    i_reg, i_next, j_reg, j_next;
    logic             start_reg, start_next;
    logic             m_valid_reg, m_valid_next;
    logic [ACT_W-1:0] act_reg;
    logic             last_i, last_j, in_accept, out_free;

    // active state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= ACT_RESET;
        end else if (cfg_we) begin
            act_reg <= cfg_wdata;
        end
    end

    // clamped state count
    always_comb begin
        if (act_reg == '0) begin
            n_act = NW'(1);
        end else if (32'(act_reg) > MAX_STATES) begin
            n_act = NW'(MAX_STATES);
        end else begin
            n_act = NW'(act_reg);
        end
    end

    always_comb begin
        last_i    = (NW'(i_reg) + NW'(1)) == n_act;
        last_j    = (NW'(j_reg) + NW'(1)) == n_act;
        in_accept = s_tvalid && s_tready;
        out_free  = !m_valid_reg || m_tready;
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        start_next   = start_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (in_op == OP_OBSERVE)) begin
                    i_next     = '0;
                    j_next     = '0;
                    start_next = in_start;
                    state_next = in_start ? ST_PREAD : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.mac_issue = 1'b1;
                cmd.row_first = (j_reg == '0);
                j_next        = j_reg + SW'(1);
                if (last_j) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_ZMUL;
            ST_ZMUL: begin
                cmd.zmul   = 1'b1;
                state_next = ST_WSTORE;
            end
            ST_PREAD: begin
                cmd.pe_read = 1'b1;
                state_next  = ST_PMUL;
            end
            ST_PMUL: begin
                cmd.pmul   = 1'b1;
                state_next = ST_WSTORE;
            end
            ST_WSTORE: begin
                cmd.w_store = 1'b1;
                if (last_i) begin
                    state_next = ST_SCALE;
                end else begin
                    i_next     = i_reg + SW'(1);
                    j_next     = '0;
                    state_next = start_reg ? ST_PREAD : ST_ISSUE;
                end
            end
            ST_SCALE: begin
                cmd.scale_clear = 1'b1;
                i_next          = '0;
                if (status.sum_zero) begin
                    state_next = ST_DIV;
                end else begin
                    cmd.div_scale = 1'b1;
                    state_next    = ST_SCALE_WAIT;
                end
            end
            ST_SCALE_WAIT: begin
                if (status.div_done) begin
                    cmd.scale_latch = 1'b1;
                    state_next      = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.sum_zero) begin
                    cmd.alpha_latch = 1'b1;
                    state_next      = ST_OUT;
                end else begin
                    cmd.div_alpha = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.alpha_latch = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = last_i;
                    if (last_i) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + SW'(1);
                        state_next = ST_DIV;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result beat valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign idx_i    = i_reg;
    assign idx_j    = j_reg;

    a_div_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_SCALE_WAIT) || (state_reg == ST_DIV_WAIT))
        else $error("division finished outside a wait state");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg || m_tready)
        else $error("result register overwritten before its beat was taken");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_last) |=> (state_reg == ST_IDLE) && m_valid_reg)
        else $error("last result beat not followed by idle");

endmodule

/* sim/hmm_sfs_checker.sv */
// beat monitor, forward-step predictor and result comparator for the hmm block
module hmm_sfs_checker
    import hmm_sfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending,
    output int          weights_seen,
    output int          zero_sums_seen
);

    typedef struct packed {
        logic [STIDX_W-1:0] state_index;
        logic [PROB_W-1:0]  alpha_value;
        logic [SCALE_W-1:0] scale_factor;
        logic               zero_sum;
        logic               last;
    } weight_t;

    localparam int NS   = DEF_MAX_STATES;
    localparam int NSYM = DEF_MAX_SYMBOLS;

    // model copy of the block state
    longint unsigned trans_tbl [NS*NS];
    longint unsigned emis_tbl  [NSYM*NS];
    longint unsigned init_tbl  [NS];
    longint unsigned fwd_vec   [NS];
    logic [ACT_W-1:0] act_reg;
    weight_t          weights_due[$];

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        $display("mismatch: %s got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    // one observation: unnormalized weights, scale and normalized vector
    task automatic forward_step(input logic [SYM_W-1:0] sym, input logic first);
        longint unsigned w[NS];
        longint unsigned total, scale, acc, e, a;
        int n;
        weight_t r;
        total = 0;
        scale = 0;
        n = (act_reg == 0) ? 1 : (act_reg > NS) ? NS : int'(act_reg);
        for (int i = 0; i < n; i++) begin
            e = emis_tbl[sym*NS + i];
            if (first) begin
                w[i] = (init_tbl[i] * e) >> PROB_FRAC_BITS;
            end else begin
                acc = 0;
                for (int j = 0; j < n; j++) acc += fwd_vec[j] * trans_tbl[j*NS + i];
                acc = acc >> PROB_FRAC_BITS;
                w[i] = (acc * e) >> PROB_FRAC_BITS;
            end
            total += w[i];
        end
        if (total != 0) begin
            scale = (64'd1 << (PROB_FRAC_BITS + 16)) / total;
            if (scale > 64'hFFFF_FFFF) scale = 64'hFFFF_FFFF;
        end
        for (int i = 0; i < NS; i++) fwd_vec[i] = 0;
        for (int i = 0; i < n; i++) begin
            a = (total != 0) ? (w[i] << PROB_FRAC_BITS) / total : 0;
            fwd_vec[i] = a;
            r.state_index  = i[STIDX_W-1:0];
            r.alpha_value  = a[PROB_W-1:0];
            r.scale_factor = scale[SCALE_W-1:0];
            r.zero_sum     = (total == 0);
            r.last         = (i == n - 1);
            weights_due.push_back(r);
        end
    endtask

    // input side: table loads and observations
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) fwd_vec[i] = 0;
            act_reg = ACT_RESET;
        end else begin
            if (cfg_we) act_reg = cfg_wdata;
            if (s_tvalid && s_tready) begin
                logic [ROW_W-1:0]  row;
                logic [COL_W-1:0]  col;
                logic [PROB_W-1:0] val;
                op_t               op;
                row = s_tdata[3:0];
                col = s_tdata[6:4];
                val = s_tdata[23:7];
                op  = op_t'(s_tuser[1:0]);
                case (op)
                    OP_LOAD_TRANS: if (row < NS) trans_tbl[row*NS + col] = val;
                    OP_LOAD_EMIS:  emis_tbl[row*NS + col] = val;
                    OP_LOAD_INIT:  if (row < NS) init_tbl[row] = val;
                    OP_OBSERVE:    forward_step(s_tdata[27:24], s_tuser[2]);
                endcase
                pending = weights_due.size();
            end
        end
    end

    // result side: compare each beat with the oldest expected weight
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            weight_t w;
            if (weights_due.size() == 0) begin
                $display("mismatch: result beat with nothing expected (t=%0t)", $realtime);
                mismatches++;
            end else begin
                w = weights_due.pop_front();
                pending = weights_due.size();
                weights_seen++;
                if (w.zero_sum) zero_sums_seen++;
                if (m_tdata[2:0] !== w.state_index)
                    report("state_index", m_tdata[2:0], w.state_index);
                if (m_tdata[19:3] !== w.alpha_value)
                    report("alpha_value", m_tdata[19:3], w.alpha_value);
                if (m_tdata[51:20] !== w.scale_factor)
                    report("scale_factor", m_tdata[51:20], w.scale_factor);
                if (m_tuser !== w.zero_sum) report("zero_sum", m_tuser, w.zero_sum);
                if (m_tlast !== w.last) report("last", m_tlast, w.last);
            end
        end
    end

    initial begin
        mismatches = 0;
        pending = 0;
        weights_seen = 0;
        zero_sums_seen = 0;
    end

endmodule

/* sim/tb_hmm_scaled_forward_step.sv */
// testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict
module tb_hmm_scaled_forward_step;
    import hmm_sfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatches, pending, weights_seen, zero_sums_seen;
    int beats_sent = 0, observations_sent = 0, idle_cycles = 0;
    int burst_left = 0;
    bit hold_off = 1'b0;
    bit done = 1'b0;

    always #6 aclk = ~aclk;

    hmm_scaled_forward_step dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    hmm_sfs_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .mismatches(mismatches), .pending(pending),
        .weights_seen(weights_seen), .zero_sums_seen(zero_sums_seen)
    );

    // receiver: ready pattern changes at random, long hold on request
    initial begin
        int mode, left, hold;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready = 1'b0;
                hold = 0;
                while (hold < 500) begin
                    @(negedge aclk);
                    hold++;
                end
                hold_off = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 1) == 1);
                2: m_tready = ($urandom_range(0, 7) != 0);
                default: m_tready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (aresetn && !done && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d weights still expected", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [PROB_W-1:0] pick_prob();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return 17'd65536;
        if (r == 2) return 17'h1FFFF;
        return 17'($urandom_range(1, 65536));
    endfunction

    // observed symbols: 0, 1, 2 and 15 (15 has all-zero emissions)
    function automatic logic [3:0] pick_sym();
        int r;
        r = $urandom_range(0, 3);
        return (r == 3) ? 4'd15 : 4'(r);
    endfunction

    // one input beat, sent in bursts with random gaps
    task automatic send_beat(input op_t op, input logic [3:0] row, input logic [2:0] col,
                             input logic [PROB_W-1:0] val, input logic [3:0] sym,
                             input logic first);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  = {4'b0, sym, val, col, row};
        s_tuser  = {first, op};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        beats_sent++;
        if (op == OP_OBSERVE) observations_sent++;
    endtask

    task automatic observe(input logic [3:0] sym, input logic first);
        send_beat(OP_OBSERVE, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                  17'($urandom), sym, first);
    endtask

    // drain, settle, then write active_states
    task automatic set_states(input logic [3:0] n);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wdata = n;
        cfg_we = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic random_beats(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 9);
            if (r < 3)
                send_beat(op_t'(2'($urandom_range(0, 2))), 4'($urandom_range(0, 15)),
                          3'($urandom_range(0, 7)), pick_prob(), 4'($urandom),
                          1'($urandom));
            else
                observe(pick_sym(), $urandom_range(0, 4) == 0);
        end
    endtask

    initial begin
        logic [3:0] phase_states[6];
        logic [3:0] sym;
        phase_states = '{4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd8};
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        set_states(4'd8);

        // fill every entry that an observation can read
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++)
                send_beat(OP_LOAD_TRANS, 4'(i), 3'(j), 17'($urandom_range(1, 65536)),
                          4'd0, 1'b0);
            send_beat(OP_LOAD_INIT, 4'(i), 3'd0, 17'($urandom_range(1, 65536)), 4'd0, 1'b0);
        end
        for (int s = 0; s < 4; s++) begin
            sym = (s == 3) ? 4'd15 : 4'(s);
            for (int j = 0; j < 8; j++)
                send_beat(OP_LOAD_EMIS, sym, 3'(j),
                          (sym == 4'd15) ? 17'd0 : 17'($urandom_range(1, 65536)),
                          4'd0, 1'b0);
        end

        // directed: extremes, ignored loads, start, chain, zero sum and recovery
        send_beat(OP_LOAD_TRANS, 4'd0, 3'd7, 17'd65536, 4'd0, 1'b0);
        send_beat(OP_LOAD_TRANS, 4'd7, 3'd0, 17'h1FFFF, 4'd0, 1'b0);
        send_beat(OP_LOAD_INIT, 4'd7, 3'd7, 17'h1FFFF, 4'd0, 1'b0);
        send_beat(OP_LOAD_EMIS, 4'd2, 3'd7, 17'h1FFFF, 4'd0, 1'b0);
        send_beat(OP_LOAD_TRANS, 4'd12, 3'd3, 17'd0, 4'd0, 1'b0);
        send_beat(OP_LOAD_INIT, 4'd9, 3'd2, 17'd0, 4'd0, 1'b0);
        send_beat(OP_LOAD_TRANS, 4'd15, 3'd7, 17'h1FFFF, 4'd0, 1'b0);
        observe(4'd2, 1'b1);
        observe(4'd0, 1'b0);
        observe(4'd2, 1'b0);
        observe(4'd15, 1'b0);
        observe(4'd1, 1'b0);
        observe(4'd15, 1'b1);
        observe(4'd1, 1'b1);
        send_beat(OP_LOAD_EMIS, 4'd2, 3'd1, 17'd0, 4'd0, 1'b0);
        send_beat(OP_LOAD_EMIS, 4'd2, 3'd1, 17'd1, 4'd0, 1'b0);
        observe(4'd2, 1'b0);

        // random phases over several state counts
        foreach (phase_states[p]) begin
            set_states(phase_states[p]);
            observe(pick_sym(), 1'b1);
            if (p == 1) begin
                hold_off = 1'b1;
                for (int k = 0; k < 4; k++) observe(4'($urandom_range(0, 2)), 1'b0);
            end
            random_beats(2);
            if (p == 3) begin
                s_tvalid = 1'b0;
                while (pending != 0) @(negedge aclk);
                random_beats(2);
            end
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        done = 1'b1;
        $display("sent %0d beats, %0d observations over 7 state-count settings",
                 beats_sent, observations_sent);
        $display("checked %0d weight beats, %0d with zero sum", weights_seen, zero_sums_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
